// ===== hw/rtl/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is low
`define TCHS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same, but also checked during reset
`define TCHS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/tchs_pkg.sv =====
package tchs_pkg;

  // command codes of an input item
  localparam logic [1:0] CMD_START   = 2'd0;
  localparam logic [1:0] CMD_TIMEOUT = 2'd1;
  localparam logic [1:0] CMD_PACKET  = 2'd2;

  // phase codes as reported in a result
  localparam logic [2:0] PHASE_IDLE     = 3'd0;
  localparam logic [2:0] PHASE_FW1      = 3'd1;
  localparam logic [2:0] PHASE_FW2      = 3'd2;
  localparam logic [2:0] PHASE_CLOSING  = 3'd3;
  localparam logic [2:0] PHASE_TW       = 3'd4;

  // configuration register map
  localparam int unsigned ADDR_W = 3;
  localparam logic [0:0] REG_RETRY_CAP = 1'd0;
  localparam logic [3:0] RETRY_CAP_RESET = 4'd5;
  localparam logic [3:0] COUNT_MAX = 4'hf;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_FW1     = 5'b00010,
    PH_FW2     = 5'b00100,
    PH_CLOSING = 5'b01000,
    PH_TW      = 5'b10000
  } phase_e;

  typedef struct packed {
    logic [1:0] command;
    logic       pkt_valid;
    logic       pkt_is_ack;
    logic       pkt_is_fin;
  } in_item_t;

  typedef struct packed {
    logic       send_fin;
    logic       send_ack;
    logic       closed;
    logic [2:0] phase;
  } out_item_t;

  typedef struct packed {
    phase_e     phase;
    logic [3:0] retry_count;
    logic [3:0] quiet_count;
  } close_state_t;

  localparam close_state_t STATE_IDLE = '{phase: PH_IDLE, retry_count: 4'd0,
                                          quiet_count: 4'd0};

  function automatic logic [2:0] phase_code(input phase_e ph);
    logic [2:0] code;
    case (ph)
      PH_FW1:     code = PHASE_FW1;
      PH_FW2:     code = PHASE_FW2;
      PH_CLOSING: code = PHASE_CLOSING;
      PH_TW:      code = PHASE_TW;
      default:    code = PHASE_IDLE;
    endcase
    return code;
  endfunction

endpackage

// ===== hw/rtl/tchs_cfg_regs.sv =====
module tchs_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tchs_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output logic [3:0]                 retry_cap_o
);
  import tchs_pkg::*;

  logic [3:0] retry_cap_q, retry_cap_d;
  logic       wr_en;
  logic       sel_max;

  assign pready  = 1'b1;
  assign sel_max = (paddr[ADDR_W-1:2] == REG_RETRY_CAP);
  assign wr_en   = psel && penable && pwrite && pready && sel_max;

  always_comb begin
    retry_cap_d = retry_cap_q;
    if (wr_en) begin
      retry_cap_d = pwdata[3:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retry_cap_q <= RETRY_CAP_RESET;
    end else begin
      retry_cap_q <= retry_cap_d;
    end
  end

  assign prdata      = sel_max ? {28'd0, retry_cap_q} : 32'd0;
  assign retry_cap_o = retry_cap_q;

endmodule

// ===== hw/rtl/tchs_next_state.sv =====
module tchs_next_state (
  input  tchs_pkg::in_item_t     item_i,
  input  tchs_pkg::close_state_t cur_i,
  input  logic [3:0]             retry_cap_i,
  output tchs_pkg::close_state_t nxt_o,
  output tchs_pkg::out_item_t    res_o
);
  import tchs_pkg::*;

  logic [3:0] retry_inc;
  logic       retry_hit;
  logic       tmo;
  logic       fin, ack, done;
  close_state_t nxt;

  // retry count saturates at its top value
  assign retry_inc = (cur_i.retry_count == COUNT_MAX) ? COUNT_MAX
                                                      : cur_i.retry_count + 4'd1;
  assign retry_hit = (retry_inc >= retry_cap_i);
  assign tmo       = (item_i.command == CMD_TIMEOUT);

  always_comb begin
    nxt  = cur_i;
    fin  = 1'b0;
    ack  = 1'b0;
    done = 1'b0;
    case (item_i.command)
      CMD_START: begin
        fin = 1'b1;
        nxt = '{phase: PH_FW1, retry_count: 4'd0, quiet_count: 4'd0};
      end
      CMD_TIMEOUT, CMD_PACKET: begin
        case (cur_i.phase)
          PH_FW1: begin
            if (tmo) begin
              fin             = 1'b1;
              nxt.retry_count = retry_inc;
              done            = retry_hit;
            end else if (!item_i.pkt_valid) begin
              fin             = 1'b1;
              nxt.retry_count = 4'd0;
            end else if (item_i.pkt_is_ack) begin
              nxt = '{phase: PH_FW2, retry_count: 4'd0, quiet_count: 4'd0};
            end else if (item_i.pkt_is_fin) begin
              ack = 1'b1;
              nxt = '{phase: PH_CLOSING, retry_count: 4'd0, quiet_count: 4'd0};
            end else begin
              nxt.retry_count = retry_inc;
              done            = retry_hit;
            end
          end
          PH_FW2: begin
            if (tmo) begin
              done = 1'b1;
            end else if (item_i.pkt_valid && item_i.pkt_is_fin) begin
              ack = 1'b1;
              nxt = '{phase: PH_TW, retry_count: 4'd0, quiet_count: 4'd0};
            end
          end
          PH_CLOSING: begin
            if (tmo) begin
              ack             = 1'b1;
              nxt.retry_count = retry_inc;
              done            = retry_hit;
            end else if (!item_i.pkt_valid) begin
              ack             = 1'b1;
              nxt.retry_count = 4'd0;
            end else if (item_i.pkt_is_ack) begin
              nxt = '{phase: PH_TW, retry_count: 4'd0, quiet_count: 4'd0};
            end else begin
              nxt.retry_count = retry_inc;
              done            = retry_hit;
            end
          end
          PH_TW: begin
            if (tmo) begin
              if (cur_i.quiet_count >= retry_cap_i) begin
                done = 1'b1;
              end else begin
                nxt.quiet_count = cur_i.quiet_count + 4'd1;
              end
            end else begin
              ack  = item_i.pkt_valid && item_i.pkt_is_fin;
              done = 1'b1;
            end
          end
          default: begin
          end
        endcase
        if (done) begin
          nxt = STATE_IDLE;
        end
      end
      default: begin
      end
    endcase
  end

  assign nxt_o = nxt;
  assign res_o = '{send_fin: fin, send_ack: ack, closed: done,
                   phase: phase_code(nxt.phase)};

endmodule

// ===== hw/rtl/transport_close_handshake_fsm.sv =====
// active-close teardown sequencer, one event in and one result out per transfer
// input channel: in_valid_i / in_stall_o carry an event (start, timeout or
//   received packet with its valid, ack and fin flags)
// output channel: out_valid_o / out_stall_i carry the result: whether to send
//   fin and/or ack, whether the teardown closed, and the phase after the event
// configuration: apb register retry_cap at byte address 0; the user must write it
//   only while no event is in flight, unchecked by the block; pready is tied high
// path: an accepted event is held in the input register, and its result is
//   registered in the result register once that register is free or draining
// throughput: one event per cycle unless the result stalls; the next-state
//   logic between the input register and the result register is the only step
// a stalled result holds; the input register still takes an event behind it
//   and only stalls the sender once both registers are full
// reset: phase idle, both counts zero, retry_cap 5, both registers empty
module transport_close_handshake_fsm (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  tchs_pkg::in_item_t           in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output tchs_pkg::out_item_t          out_data_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tchs_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import tchs_pkg::*;

  logic         in_valid_q, in_valid_d;
  in_item_t     in_q, in_d;
  logic         out_valid_q, out_valid_d;
  out_item_t    out_q, out_d;
  close_state_t state_q, state_d;
  close_state_t state_nxt;
  out_item_t    res;
  logic [3:0]   retry_cap;
  logic         fire;
  logic         in_take;

  tchs_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .retry_cap_o (retry_cap)
  );

  tchs_next_state u_next (
    .item_i      (in_q),
    .cur_i       (state_q),
    .retry_cap_i (retry_cap),
    .nxt_o       (state_nxt),
    .res_o       (res)
  );

  // the event is processed when the result register is free or draining
  assign fire       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !fire;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d  = in_valid_q;
    in_d        = in_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    state_d     = state_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (fire) begin
      in_valid_d  = 1'b0;
      out_valid_d = 1'b1;
      out_d       = res;
      state_d     = state_nxt;
    end
    if (in_take) begin
      in_valid_d = 1'b1;
      in_d       = in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= STATE_IDLE;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      state_q     <= state_d;
    end
  end

  // payload registers carry no reset
  always_ff @(posedge clk_i) begin
    in_q  <= in_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hw/rtl/tchs_checker.sv =====
`include "assert_macros.svh"

module tchs_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input tchs_pkg::out_item_t out_data_o
);
  import tchs_pkg::*;

  // the sender is held off only behind a stalled full result register
  `TCHS_ASSERT(a_stall_needs_result, clk_i, rst_ni, in_stall_o |-> (out_valid_o && out_stall_i), "input stalled without a stalled result")

  // a closing transfer always reports the idle phase
  `TCHS_ASSERT(a_closed_is_idle, clk_i, rst_ni, (out_valid_o && out_data_o.closed) |-> (out_data_o.phase == PHASE_IDLE), "closed result not idle")

  // fin and ack are never requested on the same event
  `TCHS_ASSERT(a_fin_ack_excl, clk_i, rst_ni, out_valid_o |-> !(out_data_o.send_fin && out_data_o.send_ack), "fin and ack in one result")

  // a stalled result holds until taken
  `TCHS_ASSERT(a_result_holds, clk_i, rst_ni, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)), "stalled result changed")

endmodule

bind transport_close_handshake_fsm tchs_checker u_tchs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
